// ===== design/multi_queue_linked_list_manager_assert.svh =====
// Assertion macros for the multi-queue linked-list manager.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef MULTI_QUEUE_LINKED_LIST_MANAGER_ASSERT_SVH
`define MULTI_QUEUE_LINKED_LIST_MANAGER_ASSERT_SVH
`ifndef SYNTHESIS
`define MQLL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("mqll assertion failed");
`define MQLL_ASSERT_NEXT(lbl, cond, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("mqll assertion failed");
`else
`define MQLL_ASSERT(lbl, prop)
`define MQLL_ASSERT_NEXT(lbl, cond, expr)
`endif
`endif

// ===== design/mqll_pkg.sv =====
// Package for the multi-queue linked-list manager: sizes and op codes.
// No dependencies.
package mqll_pkg;
	localparam int NODES     = 64;
	localparam int LOCATIONS = 16;
	localparam int TAG_BITS  = 16;
	localparam int QUEUES    = 2 * LOCATIONS;
	localparam int NW        = $clog2(NODES);
	localparam int LW        = (LOCATIONS > 1) ? $clog2(LOCATIONS) : 1;
	localparam int QW        = $clog2(QUEUES);

	typedef enum logic [2:0] {
		OP_APPEND_FREE = 3'd0,
		OP_APPEND_BUSY = 3'd1,
		OP_MOVE_FREE   = 3'd2,
		OP_MOVE_BUSY   = 3'd3,
		OP_PEEK        = 3'd4
	} op_t;
endpackage

// ===== design/mqll_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module mqll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== design/multi_queue_linked_list_manager.sv =====
// Multi-queue linked-list manager: doubly linked FIFO queues over a node pool.
// Append/move walk unlink, tail read, append, head read, tag read and output.
// One item at a time; the link, tail and head memory ports are walked in sequence.
// Peek starts at the head read. A new item waits until output is done, which an output stall holds.
// Reset: all queues empty, all nodes unlinked; null links kept as valid bits.
// Depends on mqll_pkg, mqll_ram and the assertion macro header.
`include "multi_queue_linked_list_manager_assert.svh"
module multi_queue_linked_list_manager (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   op,
	input  logic [5:0]                   node,
	input  logic [3:0]                   location,
	input  logic [15:0]                  manager_id,
	input  logic [15:0]                  vehicle_id,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         head_valid,
	output logic [5:0]                   head_node,
	output logic [15:0]                  head_manager,
	output logic [15:0]                  head_vehicle
);
	import mqll_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_UNL, S_RDT, S_APP, S_RDH, S_TAG, S_OUT} state_t;

	state_t                state_q;
	logic [NW-1:0]         n_q;
	logic [LW-1:0]         loc_q;
	logic                  append_q;
	logic [QW-1:0]         qn_q;
	logic [TAG_BITS-1:0]   mgr_q, veh_q;
	logic [NW-1:0]         h_q;
	logic                  hok_q;
	logic                  out_valid_q, head_valid_q;
	logic [5:0]            head_node_q;
	logic [15:0]           head_manager_q, head_vehicle_q;

	// null tracking: a clear bit means the pointer is null
	logic [NODES-1:0]      linked_q, nv_q, pv_q;
	logic [QUEUES-1:0]     hv_q, tv_q;

	// memory ports
	logic                  nxt_we, prv_we, own_we, tag_we, hd_we, tl_we;
	logic [NW-1:0]         nxt_wa, nxt_wd, prv_wa, prv_wd, own_wa;
	logic [QW-1:0]         own_wd, hd_wa, tl_wa, hd_ra, tl_ra;
	logic [NW-1:0]         hd_wd, tl_wd;
	logic                  lnk_re, hd_re, tl_re, tag_re;
	logic [NW-1:0]         lnk_ra, tag_ra;
	logic [NW-1:0]         nxt_rd, prv_rd, hd_rd, tl_rd;
	logic [QW-1:0]         own_rd;
	logic [2*TAG_BITS-1:0] tag_rd;

	logic                  in_xfer, loc_ok, node_ok, is_link_op;

	assign in_stall   = (state_q != S_IDLE);
	assign in_xfer    = in_valid && !in_stall;
	assign loc_ok     = (32'(location) < LOCATIONS);
	assign node_ok    = (32'(node) < NODES);
	assign is_link_op = (op == OP_APPEND_FREE) || (op == OP_APPEND_BUSY) ||
	                    (op == OP_MOVE_FREE) || (op == OP_MOVE_BUSY);

	mqll_ram #(.WIDTH(NW), .DEPTH(NODES)) u_next (.clk(clk), .we(nxt_we),
		.waddr(nxt_wa), .wdata(nxt_wd), .re(lnk_re), .raddr(lnk_ra), .rdata(nxt_rd));
	mqll_ram #(.WIDTH(NW), .DEPTH(NODES)) u_prev (.clk(clk), .we(prv_we),
		.waddr(prv_wa), .wdata(prv_wd), .re(lnk_re), .raddr(lnk_ra), .rdata(prv_rd));
	mqll_ram #(.WIDTH(QW), .DEPTH(NODES)) u_owner (.clk(clk), .we(own_we),
		.waddr(own_wa), .wdata(own_wd), .re(lnk_re), .raddr(lnk_ra), .rdata(own_rd));
	mqll_ram #(.WIDTH(2*TAG_BITS), .DEPTH(NODES)) u_tag (.clk(clk), .we(tag_we),
		.waddr(n_q), .wdata({mgr_q, veh_q}), .re(tag_re), .raddr(tag_ra), .rdata(tag_rd));
	mqll_ram #(.WIDTH(NW), .DEPTH(QUEUES)) u_head (.clk(clk), .we(hd_we),
		.waddr(hd_wa), .wdata(hd_wd), .re(hd_re), .raddr(hd_ra), .rdata(hd_rd));
	mqll_ram #(.WIDTH(NW), .DEPTH(QUEUES)) u_tail (.clk(clk), .we(tl_we),
		.waddr(tl_wa), .wdata(tl_wd), .re(tl_re), .raddr(tl_ra), .rdata(tl_rd));

	// memory access per step
	always_comb begin
		nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
		prv_we = 1'b0; prv_wa = '0; prv_wd = '0;
		own_we = 1'b0; own_wa = n_q; own_wd = qn_q;
		tag_we = 1'b0;
		hd_we  = 1'b0; hd_wa = '0; hd_wd = '0;
		tl_we  = 1'b0; tl_wa = '0; tl_wd = '0;
		lnk_re = in_xfer; lnk_ra = node[NW-1:0];
		tl_re  = (state_q == S_RDT); tl_ra = qn_q;
		hd_re  = (state_q == S_RDH); hd_ra = {loc_q, 1'b0};
		tag_re = (state_q == S_TAG); tag_ra = hd_rd;
		case (state_q)
			S_UNL: begin
				tag_we = append_q;
				if (linked_q[n_q]) begin
					if (pv_q[n_q]) begin
						nxt_we = nv_q[n_q]; nxt_wa = prv_rd; nxt_wd = nxt_rd;
					end else begin
						hd_we = nv_q[n_q]; hd_wa = own_rd; hd_wd = nxt_rd;
					end
					if (nv_q[n_q]) begin
						prv_we = pv_q[n_q]; prv_wa = nxt_rd; prv_wd = prv_rd;
					end else begin
						tl_we = pv_q[n_q]; tl_wa = own_rd; tl_wd = prv_rd;
					end
				end
			end
			S_APP: begin
				prv_we = tv_q[qn_q]; prv_wa = n_q; prv_wd = tl_rd;
				if (tv_q[qn_q]) begin
					nxt_we = 1'b1; nxt_wa = tl_rd; nxt_wd = n_q;
				end else begin
					hd_we = 1'b1; hd_wa = qn_q; hd_wd = n_q;
				end
				tl_we = 1'b1; tl_wa = qn_q; tl_wd = n_q;
				own_we = 1'b1;
			end
			default: ;
		endcase
	end

	// sequencer, null bits and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			linked_q    <= '0;
			nv_q        <= '0;
			pv_q        <= '0;
			hv_q        <= '0;
			tv_q        <= '0;
			out_valid_q <= 1'b0;
			hok_q       <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						n_q      <= node[NW-1:0];
						loc_q    <= location[LW-1:0];
						append_q <= (op == OP_APPEND_FREE) || (op == OP_APPEND_BUSY);
						qn_q     <= {location[LW-1:0], op[0]};
						mgr_q    <= manager_id[TAG_BITS-1:0];
						veh_q    <= vehicle_id[TAG_BITS-1:0];
						hok_q    <= 1'b0;
						if (!loc_ok) begin
							state_q <= S_OUT;
						end else if (is_link_op && node_ok) begin
							state_q <= S_UNL;
						end else begin
							state_q <= S_RDH;
						end
					end
				end
				S_UNL: begin
					if (linked_q[n_q]) begin
						if (pv_q[n_q]) begin
							nv_q[prv_rd] <= nv_q[n_q];
						end else begin
							hv_q[own_rd] <= nv_q[n_q];
						end
						if (nv_q[n_q]) begin
							pv_q[nxt_rd] <= pv_q[n_q];
						end else begin
							tv_q[own_rd] <= pv_q[n_q];
						end
					end
					linked_q[n_q] <= 1'b0;
					state_q <= S_RDT;
				end
				// the node becomes the new tail, so its next link is null
				S_RDT: begin
					nv_q[n_q] <= 1'b0;
					state_q   <= S_APP;
				end
				S_APP: begin
					pv_q[n_q] <= tv_q[qn_q];
					if (tv_q[qn_q]) begin
						nv_q[tl_rd] <= 1'b1;
					end else begin
						hv_q[qn_q] <= 1'b1;
					end
					tv_q[qn_q]     <= 1'b1;
					linked_q[n_q]  <= 1'b1;
					state_q        <= S_RDH;
				end
				S_RDH: state_q <= S_TAG;
				S_TAG: begin
					h_q     <= hd_rd;
					hok_q   <= hv_q[{loc_q, 1'b0}];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q    <= 1'b1;
						head_valid_q   <= hok_q;
						head_node_q    <= hok_q ? 6'(h_q) : '0;
						head_manager_q <= hok_q ? 16'(tag_rd[2*TAG_BITS-1:TAG_BITS]) : '0;
						head_vehicle_q <= hok_q ? 16'(tag_rd[TAG_BITS-1:0]) : '0;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign head_valid   = head_valid_q;
	assign head_node    = head_node_q;
	assign head_manager = head_manager_q;
	assign head_vehicle = head_vehicle_q;

	// sequencing checks
	`MQLL_ASSERT_NEXT(a_unl_then_tail, state_q == S_UNL, state_q == S_RDT)
	`MQLL_ASSERT_NEXT(a_app_links, state_q == S_APP, linked_q[n_q] && tv_q[qn_q] && hv_q[qn_q])
	`MQLL_ASSERT_NEXT(a_out_held, out_valid_q && out_stall, out_valid_q)
endmodule

// ===== tb/sv/mqll_checker.sv =====
// Checker for the multi-queue linked-list manager: watches both channels,
// predicts the free-queue head report for each transfer and compares.
// Depends on mqll_pkg.
module mqll_checker
	import mqll_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  op,
	input  logic [5:0]  node,
	input  logic [3:0]  location,
	input  logic [15:0] manager_id,
	input  logic [15:0] vehicle_id,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        head_valid,
	input  logic [5:0]  head_node,
	input  logic [15:0] head_manager,
	input  logic [15:0] head_vehicle,
	output int          failures,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        valid;
		logic [5:0]  idx;
		logic [15:0] mgr;
		logic [15:0] veh;
	} head_report_t;

	// link value with the top bit set means null
	logic [6:0]  nxt [NODES];
	logic [6:0]  prv [NODES];
	logic        linked [NODES];
	logic [4:0]  owner [NODES];
	logic [15:0] tag_mgr [NODES];
	logic [15:0] tag_veh [NODES];
	logic [6:0]  q_head [QUEUES];
	logic [6:0]  q_tail [QUEUES];

	head_report_t expected_heads[$];

	initial begin
		failures = 0;
		pending = 0;
		for (int i = 0; i < NODES; i++) begin
			nxt[i] = 7'h40;
			prv[i] = 7'h40;
			linked[i] = 1'b0;
			owner[i] = '0;
			tag_mgr[i] = '0;
			tag_veh[i] = '0;
		end
		for (int i = 0; i < QUEUES; i++) begin
			q_head[i] = 7'h40;
			q_tail[i] = 7'h40;
		end
	end

	// apply one item to the list state and return the free-queue head
	function automatic head_report_t apply_item(logic [2:0] code, logic [5:0] n,
			logic [3:0] loc, logic [15:0] mgr, logic [15:0] veh);
		head_report_t r;
		logic [4:0] q;
		logic [4:0] oq;
		logic [6:0] p;
		logic [6:0] x;
		logic [6:0] t;
		r = '0;
		if (code inside {OP_APPEND_FREE, OP_APPEND_BUSY, OP_MOVE_FREE, OP_MOVE_BUSY}) begin
			q = {loc, code[0]};
			// unlink from wherever the node sits
			if (linked[n]) begin
				oq = owner[n];
				p = prv[n];
				x = nxt[n];
				if (!p[6]) nxt[p[5:0]] = x;
				else q_head[oq] = x;
				if (!x[6]) prv[x[5:0]] = p;
				else q_tail[oq] = p;
			end
			if (code == OP_APPEND_FREE || code == OP_APPEND_BUSY) begin
				tag_mgr[n] = mgr;
				tag_veh[n] = veh;
			end
			// append at the tail
			t = q_tail[q];
			prv[n] = t;
			nxt[n] = 7'h40;
			if (!t[6]) nxt[t[5:0]] = {1'b0, n};
			else q_head[q] = {1'b0, n};
			q_tail[q] = {1'b0, n};
			owner[n] = q;
			linked[n] = 1'b1;
		end
		t = q_head[{loc, 1'b0}];
		if (!t[6]) begin
			r.valid = 1'b1;
			r.idx = t[5:0];
			r.mgr = tag_mgr[t[5:0]];
			r.veh = tag_veh[t[5:0]];
		end
		return r;
	endfunction

	always @(posedge clk) begin
		head_report_t exp_r;
		head_report_t got;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_heads.push_back(apply_item(op, node, location, manager_id, vehicle_id));
			if (out_valid && !out_stall) begin
				got = '{head_valid, head_node, head_manager, head_vehicle};
				if (expected_heads.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected result transfer %h at %0t", got, $time);
				end else begin
					exp_r = expected_heads.pop_front();
					if (got !== exp_r) begin
						failures++;
						if (failures <= 10)
							$display("mismatch at %0t: valid %b/%b node %0d/%0d mgr %h/%h veh %h/%h (exp/got)",
								$time, exp_r.valid, got.valid, exp_r.idx, got.idx,
								exp_r.mgr, got.mgr, exp_r.veh, got.veh);
					end
				end
			end
			pending = expected_heads.size();
		end
	end
endmodule

// ===== tb/sv/testbench.sv =====
// Top of the testbench: clock, reset, stimulus for the linked-list manager
// and the verdict. Depends on mqll_pkg, the manager RTL and mqll_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mqll_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  op = OP_PEEK;
	logic [5:0]  node = '0;
	logic [3:0]  location = '0;
	logic [15:0] manager_id = '0;
	logic [15:0] vehicle_id = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        head_valid;
	logic [5:0]  head_node;
	logic [15:0] head_manager;
	logic [15:0] head_vehicle;
	int          failures;
	int          pending;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	// nodes whose tags were written by an append
	bit tags_written [NODES];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	multi_queue_linked_list_manager DUT (.*);

	mqll_checker checker_i (.*);

	// receiver back-pressure
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// one transfer on the input channel, with optional idle gap ahead of it
	task automatic send_item(logic [2:0] code, logic [5:0] n, logic [3:0] loc,
			logic [15:0] mgr, logic [15:0] veh);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		node <= n;
		location <= loc;
		manager_id <= mgr;
		vehicle_id <= veh;
		if (code == OP_APPEND_FREE || code == OP_APPEND_BUSY) tags_written[n] = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// random item; a node with unwritten tags never enters a free queue
	task automatic send_random();
		logic [2:0] code;
		logic [5:0] n;
		logic [3:0] loc;
		int sel;
		sel = $urandom_range(99);
		n = ($urandom_range(1)) ? 6'($urandom_range(7)) : 6'($urandom);
		loc = ($urandom_range(1)) ? 4'($urandom_range(2)) : 4'($urandom);
		if (sel < 30) code = OP_APPEND_FREE;
		else if (sel < 50) code = OP_APPEND_BUSY;
		else if (sel < 70) code = OP_MOVE_FREE;
		else if (sel < 88) code = OP_MOVE_BUSY;
		else if (sel < 96) code = OP_PEEK;
		else code = 3'($urandom_range(7, 5));
		if (code == OP_MOVE_FREE && !tags_written[n]) code = OP_APPEND_FREE;
		send_item(code, n, loc, 16'($urandom), 16'($urandom));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every op, relinking, empty and unused codes
		send_item(OP_PEEK, 6'd0, 4'd0, 16'h0000, 16'h0000);
		send_item(OP_APPEND_FREE, 6'd0, 4'd0, 16'h0000, 16'h0000);
		send_item(OP_APPEND_FREE, 6'd63, 4'd15, 16'hffff, 16'hffff);
		send_item(OP_APPEND_FREE, 6'd1, 4'd0, 16'h5555, 16'haaaa);
		send_item(OP_APPEND_BUSY, 6'd5, 4'd0, 16'haaaa, 16'h5555);
		send_item(OP_MOVE_FREE, 6'd5, 4'd0, 16'h1234, 16'h4321);
		send_item(OP_MOVE_BUSY, 6'd0, 4'd0, 16'hffff, 16'hffff);
		send_item(OP_MOVE_BUSY, 6'd40, 4'd15, 16'h0000, 16'h0000);
		send_item(OP_APPEND_FREE, 6'd63, 4'd0, 16'h0f0f, 16'hf0f0);
		send_item(OP_MOVE_FREE, 6'd1, 4'd0, 16'h0, 16'h0);
		send_item(OP_MOVE_FREE, 6'd63, 4'd15, 16'h0, 16'h0);
		send_item(OP_APPEND_BUSY, 6'd40, 4'd7, 16'hbeef, 16'hcafe);
		send_item(OP_MOVE_FREE, 6'd40, 4'd7, 16'h0, 16'h0);
		send_item(OP_PEEK, 6'd0, 4'd3, 16'h0, 16'h0);
		send_item(3'd5, 6'd1, 4'd0, 16'h0, 16'h0);
		send_item(3'd6, 6'd2, 4'd15, 16'hffff, 16'hffff);
		send_item(3'd7, 6'd63, 4'd7, 16'h0, 16'h0);

		// random phases with different idle and stall mixes
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 49; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 49; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			repeat (410) send_random();
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+design
design/mqll_pkg.sv
design/mqll_ram.sv
design/multi_queue_linked_list_manager.sv
tb/sv/mqll_checker.sv
tb/sv/testbench.sv
